// ----- src/fifo_rbk_pkg.sv -----
// shared types and constants for the fifo with remove-by-key block
// no dependencies; imported by every module of the block
`default_nettype none

package fifo_rbk_pkg;

    // store geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int CODE_W = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_LIST   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // one result beat from the sequencer to the output stage
    typedef struct packed {
        logic                     valid;
        logic signed [CODE_W-1:0] value;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } result_t;

    // store access request from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [CODE_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } seq_state_t;

endpackage

`default_nettype wire

// ----- src/fifo_rbk_store.sv -----
// entry store: one write port, one read port with registered read data
// depends on fifo_rbk_pkg
`default_nettype none

module fifo_rbk_store (
    input  wire logic                          clk,
    input  wire fifo_rbk_pkg::mem_req_t        req,
    output logic [fifo_rbk_pkg::CODE_W-1:0]    rd_data
);
    import fifo_rbk_pkg::*;

    logic [CODE_W-1:0] entries_reg [QUEUE_DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entries_reg[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= entries_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/fifo_rbk_seq.sv -----
// sequencer: takes one action, walks the store one entry per cycle unless a list beat is stalled, emits results
// depends on fifo_rbk_pkg; drives fifo_rbk_store through a mem_req_t
`default_nettype none

module fifo_rbk_seq (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [fifo_rbk_pkg::ACT_W-1:0]     action,
    input  wire logic signed [fifo_rbk_pkg::CODE_W-1:0] code,
    input  wire logic                               emit_ok,
    output fifo_rbk_pkg::result_t                   res,
    output fifo_rbk_pkg::mem_req_t                  mem_req,
    input  wire logic [fifo_rbk_pkg::CODE_W-1:0]    rd_data
);
    import fifo_rbk_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dv_reg, dv_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [CODE_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]  dv_idx_reg, dv_idx_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CODE_W-1:0] head_reg, head_next;
    logic [CODE_W-1:0] rv_reg, rv_next;
    logic [STAT_W-1:0] rs_reg, rs_next;
    logic [CNT_W-1:0]  ro_reg, ro_next;

    logic              consume;
    logic              advance;
    logic              issue;
    logic [CNT_W-1:0]  idx_m1;

    assign in_ready = (state_reg == ST_IDLE);
    assign idx_m1   = dv_idx_reg - CNT_W'(1);

    // next state, store access and result beat
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        dv_next     = dv_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        rd_cnt_next = rd_cnt_reg;
        dv_idx_next = dv_idx_reg;
        kept_next   = kept_reg;
        head_next   = head_reg;
        rv_next     = rv_reg;
        rs_next     = rs_reg;
        ro_next     = ro_reg;
        consume     = 1'b0;
        advance     = 1'b0;
        issue       = 1'b0;
        mem_req     = '0;
        res         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = action;
                    key_next    = code;
                    rd_cnt_next = '0;
                    dv_next     = 1'b0;
                    kept_next   = '0;
                    rv_next     = '0;
                    if (action == ACT_PUSH)
                    begin
                        state_next = ST_DONE;
                        if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            rs_next = STATUS_FULL;
                            ro_next = count_reg;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = count_reg[IDX_W-1:0];
                            mem_req.wr_data = code;
                            count_next      = count_reg + CNT_W'(1);
                            rs_next         = STATUS_OK;
                            ro_next         = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_DONE;
                        rs_next    = STATUS_EMPTY;
                        ro_next    = '0;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                // the pending entry read from the store is consumed unless a list beat is stalled
                consume = dv_reg && ((act_reg != ACT_LIST) || emit_ok);
                advance = !dv_reg || consume;
                issue   = advance && (rd_cnt_reg < count_reg);

                if (issue)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next     = rd_cnt_reg + CNT_W'(1);
                    dv_idx_next     = rd_cnt_reg;
                end
                if (advance)
                begin
                    dv_next = issue;
                end

                if (consume)
                begin
                    priority if (act_reg == ACT_REMOVE)
                    begin
                        if (rd_data != key_reg)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = kept_reg[IDX_W-1:0];
                            mem_req.wr_data = rd_data;
                            kept_next       = kept_reg + CNT_W'(1);
                        end
                    end
                    else if (act_reg == ACT_POP)
                    begin
                        if (dv_idx_reg == '0)
                        begin
                            head_next = rd_data;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = idx_m1[IDX_W-1:0];
                            mem_req.wr_data = rd_data;
                        end
                    end
                    else
                    begin
                        res.valid     = 1'b1;
                        res.value     = rd_data;
                        res.status    = STATUS_OK;
                        res.occupancy = OCC_W'(count_reg);
                        res.last      = ((dv_idx_reg + CNT_W'(1)) == count_reg);
                    end
                end

                // walk complete: nothing left to read, nothing pending
                if (advance && !issue)
                begin
                    rv_next = '0;
                    rs_next = STATUS_OK;
                    priority if (act_reg == ACT_REMOVE)
                    begin
                        count_next = kept_next;
                        ro_next    = kept_next;
                        state_next = ST_DONE;
                    end
                    else if (act_reg == ACT_POP)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ro_next    = count_reg - CNT_W'(1);
                        rv_next    = head_next;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_DONE:
            begin
                res.valid     = 1'b1;
                res.value     = rv_reg;
                res.status    = rs_reg;
                res.occupancy = OCC_W'(ro_reg);
                res.last      = 1'b1;
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dv_reg    <= dv_next;
        end
    end

    // working registers of the current action
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        rd_cnt_reg <= rd_cnt_next;
        dv_idx_reg <= dv_idx_next;
        kept_reg   <= kept_next;
        head_reg   <= head_next;
        rv_reg     <= rv_next;
        rs_reg     <= rs_next;
        ro_reg     <= ro_next;
    end

endmodule

`default_nettype wire

// ----- src/fifo_with_remove_by_key.sv -----
// Order-keeping queue of up to QUEUE_DEPTH signed 32-bit codes with push, pop,
// remove-all-by-key and list. A push writes the store as it is accepted and gives
// one result beat. Pop and remove walk the store through its single read port,
// one entry per cycle, and then give one result beat. List gives one result beat
// per entry, one per cycle, stretched by any output stall. An action on an empty
// queue (other than push) gives one empty-status beat. A registered output stage
// lets the next action be accepted while a result waits.
// top level; depends on fifo_rbk_pkg, fifo_rbk_seq, fifo_rbk_store
`default_nettype none

module fifo_with_remove_by_key (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [fifo_rbk_pkg::ACT_W-1:0]         action,
    input  wire logic signed [fifo_rbk_pkg::CODE_W-1:0] code,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [fifo_rbk_pkg::CODE_W-1:0]      value,
    output logic [fifo_rbk_pkg::STAT_W-1:0]             status,
    output logic [fifo_rbk_pkg::OCC_W-1:0]              occupancy,
    output logic                                        last
);
    import fifo_rbk_pkg::*;

    result_t           res;
    mem_req_t          mem_req;
    logic [CODE_W-1:0] rd_data;
    logic              emit_ok;

    logic                     out_valid_reg, out_valid_next;
    logic signed [CODE_W-1:0] value_reg;
    logic [STAT_W-1:0]        status_reg;
    logic [OCC_W-1:0]         occ_reg;
    logic                     last_reg;

    // sequencer and store
    fifo_rbk_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .code     (code),
        .emit_ok  (emit_ok),
        .res      (res),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    fifo_rbk_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // output stage: takes a beat when empty or being drained
    assign emit_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_ok)
        begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ok && res.valid)
        begin
            value_reg  <= res.value;
            status_reg <= res.status;
            occ_reg    <= res.occupancy;
            last_reg   <= res.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
